@@ hw/rtl/jns_pkg.sv @@
// Package for the JSON number scanner: character codes, phase codes, result type.
`default_nettype none
package jns_pkg;

    localparam int unsigned INT_W  = 63;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned EXP_W  = 16;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned DATA_W = 168;

    localparam logic [INT_W-1:0] MAX63  = {INT_W{1'b1}};
    localparam logic [CNT_W-1:0] MAXCNT = {CNT_W{1'b1}};
    localparam logic [EXP_W-1:0] MAXEXP = {EXP_W{1'b1}};

    localparam logic [CHAR_W-1:0] C_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] C_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] C_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] C_LE    = 8'h65;
    localparam logic [CHAR_W-1:0] C_UE    = 8'h45;
    localparam logic [CHAR_W-1:0] C_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] C_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] C_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] C_SP    = 8'h20;
    localparam logic [CHAR_W-1:0] C_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] C_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] C_CR    = 8'h0D;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SIGN    = 3'd1;
    localparam logic [2:0] PH_INT     = 3'd2;
    localparam logic [2:0] PH_ZERO    = 3'd3;
    localparam logic [2:0] PH_FRAC    = 3'd4;
    localparam logic [2:0] PH_EXPSIGN = 3'd5;
    localparam logic [2:0] PH_EXPDIG  = 3'd6;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_NOINT = 1'b1;

    typedef struct packed {
        logic              status;
        logic              is_float;
        logic              negative;
        logic [INT_W-1:0]  integer_part;
        logic [INT_W-1:0]  fraction_value;
        logic [CNT_W-1:0]  fraction_digits;
        logic              exponent_negative;
        logic [EXP_W-1:0]  exponent_value;
        logic              overflow;
        logic [CHAR_W-1:0] terminator;
    } t_result;

    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage
`default_nettype wire

@@ hw/rtl/jns_in_stage.sv @@
// Input register stage: holds one character request until the scanner takes it.
`default_nettype none
module jns_in_stage (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_tvalid,
    output logic                      o_tready,
    input  wire [jns_pkg::CHAR_W-1:0] i_tdata,
    input  wire                       i_take,
    output logic                      o_valid,
    output logic [jns_pkg::CHAR_W-1:0] o_ch
);
    import jns_pkg::*;

    logic              r_valid;
    logic [CHAR_W-1:0] r_ch;

    assign o_tready = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_ch     = r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_ch <= i_tdata;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/jns_scan.sv @@
// Scanner state and per-character next-state logic with saturating accumulators.
`default_nettype none
module jns_scan (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_advance,
    input  wire [jns_pkg::CHAR_W-1:0]  i_ch,
    output logic                       o_res_valid,
    output jns_pkg::t_result           o_res
);
    import jns_pkg::*;

    logic [2:0]       r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [INT_W-1:0] r_int, n_int;
    logic [INT_W-1:0] r_frac, n_frac;
    logic [CNT_W-1:0] r_fcnt, n_fcnt;
    logic             r_eneg, n_eneg;
    logic [EXP_W-1:0] r_exp, n_exp;
    logic             r_float, n_float;
    logic             r_ovf, n_ovf;

    logic             digit, nz_digit, is_ws, is_e, fin, err;
    logic [3:0]       d;
    logic [INT_W+3:0] i_mul, f_mul;
    logic [EXP_W+3:0] e_mul;
    logic             i_sat, f_sat;

    assign digit    = (i_ch inside {[C_ZERO:C_NINE]});
    assign nz_digit = (i_ch inside {[C_ONE:C_NINE]});
    assign is_ws    = (i_ch inside {C_SP, C_TAB, C_LF, C_CR});
    assign is_e     = (i_ch == C_LE) || (i_ch == C_UE);
    assign d        = i_ch[3:0];

    // x*10 + d as shift and add, wide enough to see saturation
    assign i_mul = ({4'b0, r_int} << 3) + ({4'b0, r_int} << 1) + {{INT_W{1'b0}}, d};
    assign f_mul = ({4'b0, r_frac} << 3) + ({4'b0, r_frac} << 1) + {{INT_W{1'b0}}, d};
    assign e_mul = ({4'b0, r_exp} << 3) + ({4'b0, r_exp} << 1) + {{EXP_W{1'b0}}, d};
    assign i_sat = |i_mul[INT_W+3:INT_W];
    assign f_sat = |f_mul[INT_W+3:INT_W];

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_int   = r_int;
        n_frac  = r_frac;
        n_fcnt  = r_fcnt;
        n_eneg  = r_eneg;
        n_exp   = r_exp;
        n_float = r_float;
        n_ovf   = r_ovf;
        fin     = 1'b0;
        err     = 1'b0;
        case (r_phase)
            PH_SIGN: begin
                if (i_ch == C_ZERO) begin
                    n_phase = PH_ZERO;
                end else if (nz_digit) begin
                    n_int   = {{(INT_W-4){1'b0}}, d};
                    n_phase = PH_INT;
                end else begin
                    fin = 1'b1;
                    err = 1'b1;
                end
            end
            PH_INT, PH_ZERO: begin
                if (r_phase == PH_INT && digit) begin
                    n_int = i_sat ? MAX63 : i_mul[INT_W-1:0];
                    if (i_sat) n_ovf = 1'b1;
                end else if (i_ch == C_DOT) begin
                    n_float = 1'b1;
                    n_phase = PH_FRAC;
                end else if (is_e) begin
                    n_float = 1'b1;
                    n_phase = PH_EXPSIGN;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_FRAC: begin
                if (digit) begin
                    n_frac = f_sat ? MAX63 : f_mul[INT_W-1:0];
                    if (f_sat) n_ovf = 1'b1;
                    if (r_fcnt != MAXCNT) n_fcnt = r_fcnt + 1'b1;
                end else if (is_e) begin
                    n_float = 1'b1;
                    n_phase = PH_EXPSIGN;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_EXPSIGN, PH_EXPDIG: begin
                if (r_phase == PH_EXPSIGN && i_ch == C_PLUS) begin
                    n_phase = PH_EXPDIG;
                end else if (r_phase == PH_EXPSIGN && i_ch == C_MINUS) begin
                    n_eneg  = 1'b1;
                    n_phase = PH_EXPDIG;
                end else if (digit) begin
                    n_exp   = (|e_mul[EXP_W+3:EXP_W]) ? MAXEXP : e_mul[EXP_W-1:0];
                    n_phase = PH_EXPDIG;
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
                if (is_ws) begin
                    n_phase = r_phase;
                end else if (i_ch == C_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_SIGN;
                end else if (i_ch == C_ZERO) begin
                    n_phase = PH_ZERO;
                end else if (nz_digit) begin
                    n_int   = {{(INT_W-4){1'b0}}, d};
                    n_phase = PH_INT;
                end else begin
                    fin = 1'b1;
                    err = 1'b1;
                end
            end
        endcase
        if (fin) begin
            n_phase = PH_IDLE;
            n_neg   = 1'b0;
            n_int   = '0;
            n_frac  = '0;
            n_fcnt  = '0;
            n_eneg  = 1'b0;
            n_exp   = '0;
            n_float = 1'b0;
            n_ovf   = 1'b0;
        end
    end

    always_comb begin
        o_res_valid             = i_advance && fin;
        o_res.status            = err ? ST_NOINT : ST_OK;
        o_res.is_float          = err ? 1'b0 : r_float;
        o_res.negative          = r_neg;
        o_res.integer_part      = err ? '0 : r_int;
        o_res.fraction_value    = err ? '0 : r_frac;
        o_res.fraction_digits   = err ? '0 : r_fcnt;
        o_res.exponent_negative = err ? 1'b0 : r_eneg;
        o_res.exponent_value    = err ? '0 : r_exp;
        o_res.overflow          = err ? 1'b0 : r_ovf;
        o_res.terminator        = i_ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_neg   <= 1'b0;
            r_int   <= '0;
            r_frac  <= '0;
            r_fcnt  <= '0;
            r_eneg  <= 1'b0;
            r_exp   <= '0;
            r_float <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
            r_eneg  <= n_eneg;
            r_exp   <= n_exp;
            r_float <= n_float;
            r_ovf   <= n_ovf;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/jns_out_stage.sv @@
// Result register: holds one result request until the receiver takes it.
`default_nettype none
module jns_out_stage (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  jns_pkg::t_stage_ctl      i_ctl,
    input  jns_pkg::t_result         i_res,
    output logic                     o_free,
    output logic                     o_tvalid,
    input  wire                      i_tready,
    output jns_pkg::t_result         o_res
);
    import jns_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free   = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_res    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_ctl.valid && i_ctl.advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_ctl.valid) begin
            r_res <= i_res;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/json_number_scanner.sv @@
// Top level of the JSON number scanner.
// Usage:
//   Slave channel: one ASCII character per request in s_axis tdata[7:0].
//   Master channel: one result request per scanned number, sent when the
//   first character that cannot continue the number arrives; that character
//   is reported as the terminator and consumed. Characters that continue a
//   number or whitespace before it produce no result.
//   A character passes through the input register, then through the scanner
//   logic into the result register.
//   Throughput: one character per cycle while the receiver does not stall;
//   the scanner state is updated by a shift-and-add multiply by ten with a
//   67-bit saturation check.
//   Reset (synchronous, active low) returns the scanner to whitespace
//   skipping and empties both registers.
//   When the receiver stalls, the result register holds; the scanner stops
//   and the input register fills, then tready drops until the result is taken.
`default_nettype none
module json_number_scanner (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire [7:0]    i_s_axis_tdata,   // [7:0] ch
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // [0] is_float, [1] negative, [64:2] integer_part, [127:65] fraction_value,
    // [135:128] fraction_digits, [136] exponent_negative, [152:137] exponent_value,
    // [153] overflow, [161:154] terminator, [167:162] zero
    output logic [jns_pkg::DATA_W-1:0] o_m_axis_tdata,
    output logic         o_m_axis_tuser    // [0] status
);
    import jns_pkg::*;

    logic              in_valid, out_free, advance, res_valid;
    logic [CHAR_W-1:0] ch;
    t_result           res, out_res;
    t_stage_ctl        ctl;

    assign advance = in_valid && out_free;

    jns_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_take   (advance),
        .o_valid  (in_valid),
        .o_ch     (ch)
    );

    jns_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_ch        (ch),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign ctl.valid   = res_valid;
    assign ctl.advance = advance;

    jns_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_res    (res),
        .o_free   (out_free),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_res    (out_res)
    );

    assign o_m_axis_tuser = out_res.status;
    assign o_m_axis_tdata = {6'b0,
                             out_res.terminator,
                             out_res.overflow,
                             out_res.exponent_value,
                             out_res.exponent_negative,
                             out_res.fraction_digits,
                             out_res.fraction_value,
                             out_res.integer_part,
                             out_res.negative,
                             out_res.is_float};
endmodule
`default_nettype wire

@@ bench/jns_number_checker.sv @@
// Checker for the JSON number scanner: follows the character and result streams and compares.
module jns_number_checker
    import jns_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    input  wire         i_s_axis_tready,
    input  wire [7:0]   i_s_axis_tdata,   // [7:0] ch
    input  wire         i_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [0] is_float, [1] negative, [64:2] integer_part, [127:65] fraction_value,
    // [135:128] fraction_digits, [136] exponent_negative, [152:137] exponent_value,
    // [153] overflow, [161:154] terminator, [167:162] zero
    input  wire [167:0] i_m_axis_tdata,
    input  wire         i_m_axis_tuser,   // [0] status
    output int          o_failures,
    output int          o_pending,
    output int          o_checked,
    output int          o_rejected
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]       scan_phase = PH_IDLE;
    logic             minus_seen = 1'b0;
    logic [INT_W-1:0] int_value  = '0;
    logic [INT_W-1:0] frac_value = '0;
    logic [CNT_W-1:0] frac_count = '0;
    logic             exp_minus  = 1'b0;
    logic [EXP_W-1:0] exp_mag    = '0;
    logic             float_seen = 1'b0;
    logic             sat_seen   = 1'b0;

    t_result expected_numbers[$];
    int failures = 0;
    int pending  = 0;
    int checked  = 0;
    int rejected = 0;

    assign o_failures = failures;
    assign o_pending  = pending;
    assign o_checked  = checked;
    assign o_rejected = rejected;

    // acc*10+d, sticking at the 63-bit maximum
    function automatic logic [INT_W-1:0] times_ten_add(input logic [INT_W-1:0] acc,
                                                       input logic [3:0] d);
        logic [63:0] limit;
        limit = ({1'b0, MAX63} - 64'(d)) / 64'd10;
        if ({1'b0, acc} > limit) begin
            sat_seen = 1'b1;
            return MAX63;
        end
        return INT_W'({1'b0, acc} * 64'd10 + 64'(d));
    endfunction

    task automatic scan_char(input logic [7:0] c, output bit done, output t_result res);
        logic [3:0]  d;
        logic [31:0] e_next;
        bit          is_dig;
        bit          is_exp;
        bit          no_int;
        d      = 4'(c - C_ZERO);
        is_dig = (c >= C_ZERO) && (c <= C_NINE);
        is_exp = (c == C_LE) || (c == C_UE);
        done   = 1'b0;
        no_int = 1'b0;
        case (scan_phase)
            PH_SIGN: begin
                if (c == C_ZERO) begin
                    scan_phase = PH_ZERO;
                end else if (is_dig) begin
                    int_value  = INT_W'(d);
                    scan_phase = PH_INT;
                end else begin
                    done   = 1'b1;
                    no_int = 1'b1;
                end
            end
            PH_INT, PH_ZERO: begin
                if (scan_phase == PH_INT && is_dig) begin
                    int_value = times_ten_add(int_value, d);
                end else if (c == C_DOT) begin
                    float_seen = 1'b1;
                    scan_phase = PH_FRAC;
                end else if (is_exp) begin
                    float_seen = 1'b1;
                    scan_phase = PH_EXPSIGN;
                end else begin
                    done = 1'b1;
                end
            end
            PH_FRAC: begin
                if (is_dig) begin
                    frac_value = times_ten_add(frac_value, d);
                    if (frac_count != MAXCNT) frac_count = frac_count + 1'b1;
                end else if (is_exp) begin
                    float_seen = 1'b1;
                    scan_phase = PH_EXPSIGN;
                end else begin
                    done = 1'b1;
                end
            end
            PH_EXPSIGN, PH_EXPDIG: begin
                if (scan_phase == PH_EXPSIGN && c == C_PLUS) begin
                    scan_phase = PH_EXPDIG;
                end else if (scan_phase == PH_EXPSIGN && c == C_MINUS) begin
                    exp_minus  = 1'b1;
                    scan_phase = PH_EXPDIG;
                end else if (is_dig) begin
                    e_next     = 32'(exp_mag) * 32'd10 + 32'(d);
                    exp_mag    = (e_next > 32'(MAXEXP)) ? MAXEXP : EXP_W'(e_next);
                    scan_phase = PH_EXPDIG;
                end else begin
                    done = 1'b1;
                end
            end
            default: begin
                if (c == C_SP || c == C_TAB || c == C_LF || c == C_CR) begin
                    // skipped
                end else if (c == C_MINUS) begin
                    minus_seen = 1'b1;
                    scan_phase = PH_SIGN;
                end else if (c == C_ZERO) begin
                    scan_phase = PH_ZERO;
                end else if (is_dig) begin
                    int_value  = INT_W'(d);
                    scan_phase = PH_INT;
                end else begin
                    done   = 1'b1;
                    no_int = 1'b1;
                end
            end
        endcase
        res = '0;
        if (done) begin
            res.status     = no_int ? ST_NOINT : ST_OK;
            res.negative   = minus_seen;
            res.terminator = c;
            if (!no_int) begin
                res.is_float          = float_seen;
                res.integer_part      = int_value;
                res.fraction_value    = frac_value;
                res.fraction_digits   = frac_count;
                res.exponent_negative = exp_minus;
                res.exponent_value    = exp_mag;
                res.overflow          = sat_seen;
            end
            scan_phase = PH_IDLE;
            minus_seen = 1'b0;
            int_value  = '0;
            frac_value = '0;
            frac_count = '0;
            exp_minus  = 1'b0;
            exp_mag    = '0;
            float_seen = 1'b0;
            sat_seen   = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result next_res;
        bit      emits;
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_numbers.size() == 0) begin
                    $error("unexpected result, terminator 0x%0h", i_m_axis_tdata[161:154]);
                    failures++;
                end else begin
                    want = expected_numbers.pop_front();
                    checked++;
                    if (want.status == ST_NOINT) rejected++;
                    check_field("status", 64'(want.status), 64'(i_m_axis_tuser));
                    check_field("is_float", 64'(want.is_float), 64'(i_m_axis_tdata[0]));
                    check_field("negative", 64'(want.negative), 64'(i_m_axis_tdata[1]));
                    check_field("integer_part", 64'(want.integer_part),
                                64'(i_m_axis_tdata[64:2]));
                    check_field("fraction_value", 64'(want.fraction_value),
                                64'(i_m_axis_tdata[127:65]));
                    check_field("fraction_digits", 64'(want.fraction_digits),
                                64'(i_m_axis_tdata[135:128]));
                    check_field("exponent_negative", 64'(want.exponent_negative),
                                64'(i_m_axis_tdata[136]));
                    check_field("exponent_value", 64'(want.exponent_value),
                                64'(i_m_axis_tdata[152:137]));
                    check_field("overflow", 64'(want.overflow), 64'(i_m_axis_tdata[153]));
                    check_field("terminator", 64'(want.terminator),
                                64'(i_m_axis_tdata[161:154]));
                    check_field("padding", 64'd0, 64'(i_m_axis_tdata[167:162]));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                scan_char(i_s_axis_tdata, emits, next_res);
                if (emits) expected_numbers.push_back(next_res);
            end
            pending = expected_numbers.size();
        end
    end

endmodule

@@ bench/tb.sv @@
// Testbench top for the JSON number scanner: character stimulus, handshake pressure, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import jns_pkg::*;

    logic         clk     = 1'b0;
    logic         rst_n   = 1'b0;
    logic         s_valid = 1'b0;
    logic [7:0]   s_data  = '0;
    logic         s_ready;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [167:0] m_data;
    logic         m_user;

    int failures;
    int pending;
    int checked;
    int rejected;

    logic [7:0] char_q[$];
    logic [7:0] blanks[4]  = '{C_SP, C_TAB, C_LF, C_CR};
    logic [7:0] closers[5] = '{8'h2C, 8'h5D, 8'h7D, C_SP, C_LF};

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    json_number_scanner u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    jns_number_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_rejected      (rejected)
    );

    // mostly short runs, some long enough to saturate the 63-bit accumulators
    function automatic int run_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return $urandom_range(0, 4);
        if (pick < 96) return $urandom_range(15, 22);
        return $urandom_range(5, 40);
    endfunction

    task automatic push_digits(input int count);
        repeat (count) char_q.push_back(8'(C_ZERO + $urandom_range(0, 9)));
    endtask

    // one number with random content, or one to three random characters; frac_len >= 0 forces a fraction of that length
    task automatic add_number(input int frac_len);
        int pick;
        int sign_pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 3)) char_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) char_q.push_back(blanks[$urandom_range(0, 3)]);
        if ($urandom_range(0, 99) < 40) char_q.push_back(C_MINUS);
        if (pick < 17) begin
            char_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 99) < 15) begin
            char_q.push_back(C_ZERO);
        end else begin
            char_q.push_back(8'(C_ONE + $urandom_range(0, 8)));
            push_digits(run_length());
        end
        if (frac_len >= 0 || $urandom_range(0, 99) < 40) begin
            char_q.push_back(C_DOT);
            push_digits(frac_len >= 0 ? frac_len : run_length());
        end
        if ($urandom_range(0, 99) < 35) begin
            char_q.push_back($urandom_range(0, 1) ? C_LE : C_UE);
            sign_pick = $urandom_range(0, 2);
            if (sign_pick == 1) char_q.push_back(C_PLUS);
            if (sign_pick == 2) char_q.push_back(C_MINUS);
            push_digits($urandom_range(0, 99) < 20 ? $urandom_range(4, 7)
                                                   : $urandom_range(0, 3));
        end
        if ($urandom_range(0, 99) < 25) char_q.push_back(8'($urandom_range(0, 255)));
        else char_q.push_back(closers[$urandom_range(0, 4)]);
    endtask

    // receiver: random stalls, one long hold-off, one stretch always ready
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= 300 && cycles < 364) m_ready <= 1'b0;
            else if (cycles >= 500 && cycles < 800) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 99) >= 23);
        end
    end

    initial begin
        string directed;
        int    sent;
        directed = "-0.5E+9,01 x---7e-2";
        char_q.push_back(C_SP);
        char_q.push_back(C_TAB);
        char_q.push_back(C_CR);
        char_q.push_back(C_LF);
        for (int i = 0; i < directed.len(); i++) char_q.push_back(directed[i]);
        char_q.push_back(8'hFF);
        // fraction long enough to saturate the digit count, when add_number does not emit stray characters instead
        add_number(258);
        while (char_q.size() < 700) add_number(-1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        sent = 0;
        while (sent < char_q.size()) begin
            @(posedge clk);
            if (s_valid && s_ready) sent++;
            if (!s_valid || s_ready) begin
                if (sent < char_q.size() &&
                    ((sent >= 400 && sent < 600) || $urandom_range(0, 99) >= 23)) begin
                    s_valid <= 1'b1;
                    s_data  <= char_q[sent];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end

        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Scanned %0d characters; %0d numbers compared, %0d of them rejected",
                 char_q.size(), checked, rejected);
        $display("for a missing integer digit, with a %0d-cycle output hold-off.", 64);
        if (failures == 0) begin
            $display("[json_number_scanner] OK");
        end else begin
            $display("[json_number_scanner] ERROR");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("[json_number_scanner] ERROR");
        $finish;
    end

endmodule
